[rtl/nvt_pkg.sv]
// shared types, codes and constants of the named value table
package nvt_pkg;

  localparam int W_POS  = 6;
  localparam int W_KLEN = 7;
  localparam int W_IDX  = 8;
  localparam int W_USED = 9;

  localparam logic [2:0] ACT_GET   = 3'd0;
  localparam logic [2:0] ACT_SET   = 3'd1;
  localparam logic [2:0] ACT_CLEAR = 3'd2;
  localparam logic [2:0] ACT_RESET = 3'd3;
  localparam logic [2:0] ACT_STEP  = 3'd4;

  localparam logic [2:0] ST_FOUND   = 3'd0;
  localparam logic [2:0] ST_CLAIMED = 3'd1;
  localparam logic [2:0] ST_TOOLONG = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOENTRY = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  localparam logic [1:0] TOK_MATCH  = 2'd0;
  localparam logic [1:0] TOK_ACCESS = 2'd1;
  localparam logic [1:0] TOK_CLEAR  = 2'd2;
  localparam logic [1:0] TOK_RESET  = 2'd3;

  localparam int         PREFIX_LEN = 4;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  typedef struct packed {
    logic              byte_vld;
    logic [7:0]        kbyte;
    logic [W_POS-1:0]  pos;
    logic              key_wr;
    logic              tok_vld;
    logic [1:0]        op;
    logic [W_KLEN-1:0] klen;
    logic [W_USED-1:0] used;
    logic [W_IDX-1:0]  target;
    logic              val_wr;
    logic [31:0]       val;
    logic              hit;
    logic [W_IDX-1:0]  hit_idx;
  } cell_bus_t;

  typedef struct packed {
    logic              prefix_seen;
    logic [W_KLEN-1:0] name_length;
  } name_info_t;

  function automatic logic [7:0] prefix_byte(input logic [1:0] i);
    logic [7:0] b;
    unique case (i)
      2'd0: b = 8'h6d;
      2'd1: b = 8'h73;
      2'd2: b = 8'h67;
      default: b = 8'h5f;
    endcase
    return b;
  endfunction

endpackage

[rtl/nvt_if.sv]
// channel interfaces: request, response and pool size write
interface nvt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  name_char;
  logic        char_present;
  logic        last_char;
  logic        by_slot;
  logic [3:0]  slot;
  logic [31:0] value;
  modport source(output valid, action, name_char, char_present, last_char, by_slot, slot,
                 value, input ready);
  modport sink(input valid, action, name_char, char_present, last_char, by_slot, slot,
               value, output ready);
endinterface

interface nvt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot_index;
  logic [31:0] slot_value;
  modport source(output valid, status, slot_index, slot_value, input ready);
  modport sink(input valid, status, slot_index, slot_value, output ready);
endinterface

interface nvt_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] pool_size;
  modport source(output valid, pool_size, input ready);
  modport sink(input valid, pool_size, output ready);
endinterface

[rtl/nvt_name.sv]
// name collector: case folding, prefix detection and key byte lookup
module nvt_name import nvt_pkg::*; #(
  parameter int KEY_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_en,
  input  logic [7:0]       char_in,
  input  logic             clear,
  input  logic [W_POS-1:0] rd_pos,
  output name_info_t       info,
  output logic [7:0]       key_byte
);
  localparam int KI = $clog2(KEY_BYTES);

  logic [7:0]        buffer [KEY_BYTES-1];
  logic [W_KLEN-1:0] name_length;
  logic [2:0]        progress;
  logic              prefix_seen;
  logic              ended;
  logic [7:0]        lc;
  logic [2:0]        progress_next;
  logic [W_POS-1:0]  rel_pos;

  assign lc = (char_in >= 8'h41 && char_in <= 8'h5a) ? (char_in | CASE_BIT) : char_in;

  always_comb begin
    if (lc == prefix_byte(progress[1:0])) begin
      progress_next = progress + 3'd1;
    end else begin
      progress_next = (lc == prefix_byte(2'd0)) ? 3'd1 : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      name_length <= '0;
      progress    <= '0;
      prefix_seen <= 1'b0;
      ended       <= 1'b0;
    end else if (char_en && !ended) begin
      if (char_in == 8'h00) begin
        ended <= 1'b1;
      end else begin
        if (name_length < W_KLEN'(KEY_BYTES)) begin
          name_length <= name_length + W_KLEN'(1);
        end
        if (progress_next == 3'(PREFIX_LEN)) begin
          prefix_seen <= 1'b1;
          progress    <= '0;
        end else begin
          progress <= progress_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_en && !ended && char_in != 8'h00 && name_length < W_KLEN'(KEY_BYTES - 1)) begin
      buffer[name_length[KI-1:0]] <= lc;
    end
  end

  assign rel_pos = prefix_seen ? rd_pos : rd_pos - W_POS'(PREFIX_LEN);

  always_comb begin
    if (!prefix_seen && rd_pos < W_POS'(PREFIX_LEN)) begin
      key_byte = prefix_byte(rd_pos[1:0]);
    end else begin
      key_byte = buffer[rel_pos[KI-1:0]];
    end
  end

  assign info.prefix_seen = prefix_seen;
  assign info.name_length = name_length;

endmodule

[rtl/nvt_cell.sv]
// one slot: key bytes, key length and value, passing the bus to its neighbor
module nvt_cell import nvt_pkg::*; #(
  parameter int IDX       = 0,
  parameter int KEY_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_bus_t bus_in,
  output cell_bus_t bus_out
);
  localparam int KI = $clog2(KEY_BYTES);

  logic [7:0]        key [KEY_BYTES-1];
  logic [W_KLEN-1:0] key_len;
  logic [31:0]       val;
  logic              mism;
  logic [7:0]        key_byte;
  logic              mine;
  logic              active;
  cell_bus_t         nxt;

  assign key_byte = key[bus_in.pos[KI-1:0]];
  assign mine     = bus_in.target == W_IDX'(IDX);
  assign active   = W_USED'(IDX) < bus_in.used;

  always_ff @(posedge clk) begin
    if (bus_in.byte_vld) begin
      if (bus_in.key_wr) begin
        if (mine) begin
          key[bus_in.pos[KI-1:0]] <= bus_in.kbyte;
        end
      end else if (bus_in.pos == '0) begin
        mism <= key_byte != bus_in.kbyte;
      end else begin
        mism <= mism | (key_byte != bus_in.kbyte);
      end
    end
    if (bus_in.tok_vld && bus_in.op == TOK_ACCESS && mine && bus_in.key_wr) begin
      key_len <= bus_in.klen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else if (bus_in.tok_vld) begin
      unique case (bus_in.op)
        TOK_ACCESS: if (mine && bus_in.val_wr) val <= bus_in.val;
        TOK_CLEAR:  if (active) val <= '0;
        TOK_RESET:  val <= '0;
        default: ;
      endcase
    end
  end

  always_comb begin
    nxt = bus_in;
    if (bus_in.tok_vld) begin
      unique case (bus_in.op)
        TOK_MATCH: begin
          if (!bus_in.hit && active && key_len == bus_in.klen && !mism) begin
            nxt.hit     = 1'b1;
            nxt.hit_idx = W_IDX'(IDX);
          end
        end
        TOK_ACCESS: begin
          if (mine) begin
            nxt.val = bus_in.val_wr ? bus_in.val : val;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.byte_vld <= 1'b0;
      bus_out.tok_vld  <= 1'b0;
    end else begin
      bus_out.byte_vld <= nxt.byte_vld;
      bus_out.tok_vld  <= nxt.tok_vld;
    end
    bus_out.kbyte   <= nxt.kbyte;
    bus_out.pos     <= nxt.pos;
    bus_out.key_wr  <= nxt.key_wr;
    bus_out.op      <= nxt.op;
    bus_out.klen    <= nxt.klen;
    bus_out.used    <= nxt.used;
    bus_out.target  <= nxt.target;
    bus_out.val_wr  <= nxt.val_wr;
    bus_out.val     <= nxt.val;
    bus_out.hit     <= nxt.hit;
    bus_out.hit_idx <= nxt.hit_idx;
  end

endmodule

[rtl/named_value_table_with_pool_claim_unit.sv]
// top level: request sequencer driving a row of slot cells
//
//   channel | dir | words
//   req     | in  | action, name byte, flags, slot, value
//   rsp     | out | status, slot index, slot value (one per last item of a known action)
//   cfg     | in  | pool size
//
// a name byte is taken while the sequencer is idle; a last item sends one token down the
// cell row for a direct access, and for a name lookup with claim the key bytes walk the
// cell row once to compare and once to write
// reset is synchronous and leaves every slot value zero, no clearing pass
// a result waits in the output register while req is taken again; only the next
// result stalls in the sequencer until the waiting one leaves
module named_value_table_with_pool_claim_unit import nvt_pkg::*; #(
  parameter int CAPACITY  = 16,
  parameter int KEY_BYTES = 32
) (
  input  logic  clk,
  input  logic  rst,
  nvt_req_if.sink   req,
  nvt_rsp_if.source rsp,
  nvt_cfg_if.sink   cfg
);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = (CW > 5) ? CW : 5;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_FEED = 3'd2;
  localparam logic [2:0] S_TOK  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0]       state;
  logic [2:0]       op_action;
  logic             op_by_slot;
  logic [3:0]       op_slot;
  logic [31:0]      op_value;
  logic [4:0]       pool_size;
  logic [NW-1:0]    pool_count;
  logic [NW-1:0]    used;
  logic [W_POS-1:0] feed_pos;
  logic             claim;
  logic [2:0]       res_status;
  logic [W_IDX-1:0] res_idx;
  logic [31:0]      res_val;
  logic [W_IDX-1:0] acc_target;
  logic             out_vld;
  logic [2:0]       out_status;
  logic [3:0]       out_idx;
  logic [31:0]      out_val;

  logic             accept;
  logic             name_clear;
  name_info_t       info;
  logic [7:0]       key_byte;
  logic [W_KLEN-1:0] klen;
  logic             too_long;
  logic [4:0]       step_idx;
  logic             full;
  cell_bus_t        bus_head;
  cell_bus_t        bus [CAPACITY+1];
  cell_bus_t        bus_end;

  assign accept     = req.valid && req.ready;
  assign req.ready  = state == S_IDLE;
  assign cfg.ready  = 1'b1;
  assign name_clear = state == S_RESP && (!out_vld || rsp.ready);

  nvt_name #(.KEY_BYTES(KEY_BYTES)) u_name (
    .clk      (clk),
    .rst      (rst),
    .char_en  (accept && req.char_present),
    .char_in  (req.name_char),
    .clear    (name_clear),
    .rd_pos   (feed_pos),
    .info     (info),
    .key_byte (key_byte)
  );

  always_comb begin
    if (info.prefix_seen) begin
      klen     = info.name_length;
      too_long = info.name_length > W_KLEN'(KEY_BYTES - 1);
    end else begin
      klen     = info.name_length + W_KLEN'(PREFIX_LEN);
      too_long = ({1'b0, info.name_length} + 8'(PREFIX_LEN)) > 8'(KEY_BYTES - 2);
    end
  end

  assign step_idx = op_by_slot ? {1'b0, op_slot} + 5'd1 : 5'd0;
  assign full     = used >= pool_count || W_USED'(used) >= W_USED'(CAPACITY);

  // word fed into the first cell
  always_comb begin
    bus_head          = '0;
    bus_head.used     = W_USED'(used);
    bus_head.klen     = klen;
    bus_head.pos      = feed_pos;
    bus_head.kbyte    = key_byte;
    bus_head.key_wr   = claim;
    bus_head.target   = claim ? W_IDX'(used) : acc_target;
    bus_head.val      = op_value;
    unique case (state)
      S_FEED: bus_head.byte_vld = 1'b1;
      S_TOK: begin
        bus_head.tok_vld = 1'b1;
        bus_head.op      = claim ? TOK_ACCESS : TOK_MATCH;
        bus_head.val_wr  = claim && op_action == ACT_SET;
      end
      S_ACC: begin
        bus_head.tok_vld = 1'b1;
        bus_head.key_wr  = 1'b0;
        bus_head.target  = acc_target;
        bus_head.val_wr  = op_action == ACT_SET;
        if (op_action == ACT_CLEAR) begin
          bus_head.op = TOK_CLEAR;
        end else if (op_action == ACT_RESET) begin
          bus_head.op = TOK_RESET;
        end else begin
          bus_head.op = TOK_ACCESS;
        end
      end
      default: ;
    endcase
  end

  assign bus[0] = bus_head;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    nvt_cell #(.IDX(i), .KEY_BYTES(KEY_BYTES)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .bus_in  (bus[i]),
      .bus_out (bus[i+1])
    );
  end

  assign bus_end = bus[CAPACITY];

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= 5'd16;
    end else if (cfg.valid && cfg.ready) begin
      pool_size <= cfg.pool_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      pool_count <= (CAPACITY < 16) ? NW'(CAPACITY) : NW'(16);
      out_vld    <= 1'b0;
      claim      <= 1'b0;
    end else begin
      if (out_vld && rsp.ready && state != S_RESP) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && req.last_char) begin
            op_action  <= req.action;
            op_by_slot <= req.by_slot;
            op_slot    <= req.slot;
            op_value   <= req.value;
            state      <= S_DISP;
          end
        end
        S_DISP: begin
          res_status <= ST_NOENTRY;
          res_idx    <= '0;
          res_val    <= '0;
          acc_target <= '0;
          claim      <= 1'b0;
          feed_pos   <= '0;
          unique case (op_action)
            ACT_GET, ACT_SET: begin
              if (op_by_slot) begin
                if ({1'b0, op_slot} < NW'(pool_count) &&
                    W_USED'(op_slot) < W_USED'(CAPACITY)) begin
                  res_status <= ST_FOUND;
                  acc_target <= W_IDX'(op_slot);
                  state      <= S_ACC;
                end else begin
                  state <= S_RESP;
                end
              end else if (too_long) begin
                res_status <= ST_TOOLONG;
                state      <= S_RESP;
              end else begin
                state <= S_FEED;
              end
            end
            ACT_CLEAR: begin
              res_status <= ST_DONE;
              state      <= S_ACC;
            end
            ACT_RESET: begin
              res_status <= ST_DONE;
              used       <= '0;
              pool_count <= (W_USED'(pool_size) > W_USED'(CAPACITY)) ? NW'(CAPACITY)
                                                                     : NW'(pool_size);
              state      <= S_ACC;
            end
            ACT_STEP: begin
              if (NW'(step_idx) < used && W_USED'(step_idx) < W_USED'(CAPACITY)) begin
                res_status <= ST_FOUND;
                acc_target <= W_IDX'(step_idx);
                state      <= S_ACC;
              end else begin
                state <= S_RESP;
              end
            end
            default: state <= S_RESP;
          endcase
        end
        S_FEED: begin
          feed_pos <= feed_pos + W_POS'(1);
          if (W_KLEN'(feed_pos) == klen - W_KLEN'(1)) begin
            state <= S_TOK;
          end
        end
        S_TOK: begin
          if (claim) begin
            used       <= used + NW'(1);
            res_status <= ST_CLAIMED;
          end
          state <= S_WAIT;
        end
        S_ACC: state <= S_WAIT;
        S_WAIT: begin
          if (bus_end.tok_vld) begin
            if (bus_end.op == TOK_MATCH) begin
              feed_pos <= '0;
              if (bus_end.hit) begin
                res_status <= ST_FOUND;
                acc_target <= bus_end.hit_idx;
                state      <= S_ACC;
              end else if (full) begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                claim <= 1'b1;
                state <= S_FEED;
              end
            end else if (bus_end.op == TOK_ACCESS) begin
              res_idx <= bus_end.target;
              res_val <= bus_end.val;
              claim   <= 1'b0;
              state   <= S_RESP;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (!out_vld || rsp.ready) begin
            out_vld    <= op_action <= ACT_STEP;
            out_status <= res_status;
            out_idx    <= res_idx[3:0];
            out_val    <= res_val;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid      = out_vld;
  assign rsp.status     = out_status;
  assign rsp.slot_index = out_idx;
  assign rsp.slot_value = out_val;

endmodule

[sim/named_value_table_with_pool_claim_unit_test.sv]
// testbench: named value table driven by name words, checked against its own table model
`timescale 1ns / 100ps

module named_value_table_with_pool_claim_unit_test;
  import nvt_pkg::*;

  localparam int SLOTS    = 16;
  localparam int KEY_MAX  = 32;
  localparam int SETTLE   = 120;
  localparam int HOLD_LEN = 400;
  localparam int LIMIT    = 2000000;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] slot_value;
  } answer_t;

  typedef struct {
    logic [2:0]  action;
    logic [7:0]  name_char;
    logic        char_present;
    logic        last_char;
    logic        by_slot;
    logic [3:0]  slot;
    logic [31:0] value;
    bit          typed;
    answer_t     ans;
  } stim_row_t;

  logic clk;
  logic rst;

  nvt_req_if req ();
  nvt_rsp_if rsp ();
  nvt_cfg_if cfg ();

  named_value_table_with_pool_claim_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // table model state
  logic [4:0]  size_reg;
  int          pool_count;
  int          used_slots;
  logic [31:0] slot_vals [SLOTS];
  logic [7:0]  slot_keys [SLOTS][KEY_MAX];
  int          slot_klen [SLOTS];
  logic [7:0]  name_buf [KEY_MAX];
  int          name_len;
  int          match_prog;
  bit          has_prefix;
  bit          name_done;
  logic [7:0]  pfx [4] = '{8'h6d, 8'h73, 8'h67, 8'h5f};

  answer_t     answer_q [$];
  int          errors;
  int          cycles;
  bit          hold_go;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic clear_name();
    name_len   = 0;
    match_prog = 0;
    has_prefix = 0;
    name_done  = 0;
  endtask

  task automatic reset_pool();
    used_slots = 0;
    pool_count = (size_reg > SLOTS) ? SLOTS : int'(size_reg);
    for (int i = 0; i < SLOTS; i++) begin
      slot_vals[i] = '0;
      slot_klen[i] = 0;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    logic [7:0] lc;
    if (name_done) return;
    if (c == 8'h00) begin
      name_done = 1;
      return;
    end
    lc = (c >= "A" && c <= "Z") ? c + CASE_BIT : c;
    if (name_len < KEY_MAX - 1) name_buf[name_len] = lc;
    if (name_len < KEY_MAX) name_len++;
    if (match_prog < 4 && lc == pfx[match_prog]) match_prog++;
    else match_prog = (lc == pfx[0]) ? 1 : 0;
    if (match_prog >= 4) begin
      has_prefix = 1;
      match_prog = 0;
    end
  endtask

  // finds or claims the slot of the current name
  task automatic find_or_claim(output logic [2:0] st, output int idx);
    logic [7:0] key [KEY_MAX];
    int         klen;
    bit         same;
    idx = 0;
    if (has_prefix) begin
      if (name_len > KEY_MAX - 1) begin
        st = ST_TOOLONG;
        return;
      end
      for (int i = 0; i < name_len; i++) key[i] = name_buf[i];
      klen = name_len;
    end else begin
      if (name_len + 4 > KEY_MAX - 2) begin
        st = ST_TOOLONG;
        return;
      end
      for (int i = 0; i < 4; i++) key[i] = pfx[i];
      for (int i = 0; i < name_len; i++) key[i + 4] = name_buf[i];
      klen = name_len + 4;
    end
    for (int i = 0; i < used_slots; i++) begin
      same = (slot_klen[i] == klen);
      for (int j = 0; j < klen; j++) if (slot_keys[i][j] != key[j]) same = 0;
      if (same) begin
        st  = ST_FOUND;
        idx = i;
        return;
      end
    end
    if (used_slots >= pool_count) begin
      st = ST_FULL;
      return;
    end
    idx = used_slots;
    for (int j = 0; j < klen; j++) slot_keys[idx][j] = key[j];
    slot_klen[idx] = klen;
    used_slots++;
    st = ST_CLAIMED;
  endtask

  task automatic predict_word(input stim_row_t w, output bit has_ans, output answer_t a);
    logic [2:0] st;
    int         idx;
    int         nxt;
    has_ans = 0;
    a = '{ST_NOENTRY, 4'd0, 32'd0};
    if (w.char_present) take_char(w.name_char);
    if (!w.last_char) return;
    has_ans = 1;
    case (w.action)
      ACT_GET, ACT_SET: begin
        st = ST_NOENTRY;
        idx = 0;
        if (w.by_slot) begin
          if (w.slot < pool_count) begin
            st = ST_FOUND;
            idx = w.slot;
          end
        end else begin
          find_or_claim(st, idx);
        end
        if (st == ST_FOUND || st == ST_CLAIMED) begin
          if (w.action == ACT_SET) slot_vals[idx] = w.value;
          a = '{st, idx[3:0], slot_vals[idx]};
        end else begin
          a = '{st, 4'd0, 32'd0};
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < used_slots; i++) slot_vals[i] = '0;
        a.status = ST_DONE;
      end
      ACT_RESET: begin
        reset_pool();
        a.status = ST_DONE;
      end
      ACT_STEP: begin
        nxt = w.by_slot ? int'(w.slot) + 1 : 0;
        if (nxt < used_slots) a = '{ST_FOUND, nxt[3:0], slot_vals[nxt]};
      end
      default: has_ans = 0;
    endcase
    clear_name();
  endtask

  // drives one word and waits until it is taken
  task automatic send_word(input stim_row_t w);
    bit      has_ans;
    answer_t a;
    req.valid        <= 1'b1;
    req.action       <= w.action;
    req.name_char    <= w.name_char;
    req.char_present <= w.char_present;
    req.last_char    <= w.last_char;
    req.by_slot      <= w.by_slot;
    req.slot         <= w.slot;
    req.value        <= w.value;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
    predict_word(w, has_ans, a);
    if (has_ans) answer_q.push_back(w.typed ? w.ans : a);
  endtask

  int burst_left;

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20);
    gap = $urandom_range(1, 8);
    req.valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pool_size(input logic [4:0] v);
    cfg.valid     <= 1'b1;
    cfg.pool_size <= v;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    cfg.valid <= 1'b0;
    size_reg = v;
  endtask

  function automatic stim_row_t word(input logic [2:0] act, input logic [7:0] ch,
                                     input logic pres, input logic last);
    stim_row_t w;
    w.action       = act;
    w.name_char    = ch;
    w.char_present = pres;
    w.last_char    = last;
    w.by_slot      = 1'($urandom_range(0, 1));
    w.slot         = 4'($urandom_range(0, 15));
    w.value        = $urandom;
    w.typed        = 0;
    w.ans          = '{ST_NOENTRY, 4'd0, 32'd0};
    return w;
  endfunction

  function automatic logic [7:0] twist_case(input logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
      return c ^ CASE_BIT;
    return c;
  endfunction

  // one get or set by name, with random spelling, stray zero or high bytes and interleaved words
  task automatic send_named(input logic [2:0] act);
    string      vocab [9] = '{"Alpha", "beta", "x", "MSG_rate", "gmsg_x", "msg_", "ms",
                              "m_sg", "speed"};
    logic [7:0] chars [$];
    int         kind;
    int         n;
    stim_row_t  w;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      string s;
      s = vocab[$urandom_range(0, 8)];
      for (int i = 0; i < s.len(); i++) chars.push_back(twist_case(s[i]));
    end else if (kind < 85) begin
      n = $urandom_range(1, 6);
      repeat (n) chars.push_back(twist_case(8'($urandom_range(97, 122))));
    end else if (kind < 95) begin
      n = $urandom_range(22, 36);
      if ($urandom_range(0, 1)) begin
        chars.push_back("m"); chars.push_back("S"); chars.push_back("g"); chars.push_back("_");
      end
      repeat (n) chars.push_back(8'($urandom_range(97, 122)));
    end
    if (chars.size() > 0 && $urandom_range(0, 19) == 0)
      chars.insert($urandom_range(0, chars.size() - 1), 8'h00);
    if (chars.size() > 0 && $urandom_range(0, 9) == 0)
      chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(128, 255));
    for (int i = 0; i < chars.size(); i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_word(word(3'($urandom), 8'($urandom), 1'b0, 1'b0));
        pace();
      end
      w = word(3'($urandom), chars[i], 1'b1, 1'b0);
      if (i == chars.size() - 1) begin
        w.action    = act;
        w.last_char = 1'b1;
        w.by_slot   = 1'b0;
      end
      send_word(w);
      pace();
    end
    if (chars.size() == 0) begin
      w = word(act, 8'($urandom), 1'b0, 1'b1);
      w.by_slot = 1'b0;
      send_word(w);
      pace();
    end
  endtask

  task automatic send_random_request();
    int        pick;
    stim_row_t w;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_named($urandom_range(0, 1) ? ACT_SET : ACT_GET);
    end else begin
      if (pick < 60) begin
        w = word($urandom_range(0, 1) ? ACT_SET : ACT_GET, 8'($urandom), 1'($urandom), 1'b1);
        w.by_slot = 1'b1;
      end else if (pick < 74) begin
        w = word(ACT_STEP, 8'($urandom), 1'($urandom), 1'b1);
        if ($urandom_range(0, 1)) w.slot = 4'($urandom_range(0, 3));
      end else if (pick < 78) begin
        w = word(ACT_CLEAR, 8'($urandom), 1'($urandom), 1'b1);
      end else if (pick < 80) begin
        w = word(ACT_RESET, 8'($urandom), 1'($urandom), 1'b1);
      end else if (pick < 83) begin
        w = word(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 1'b1);
      end else begin
        // noise: anything at all
        w = word(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
      send_word(w);
      pace();
    end
  endtask

  stim_row_t directed [$];

  function automatic stim_row_t row(input logic [2:0] act, input logic [7:0] ch,
                                    input logic pres, input logic last, input logic bys,
                                    input logic [3:0] sl, input logic [31:0] v);
    stim_row_t w;
    w = '{act, ch, pres, last, bys, sl, v, 1'b0, '{ST_NOENTRY, 4'd0, 32'd0}};
    return w;
  endfunction

  function automatic stim_row_t known(input stim_row_t w, input logic [2:0] st,
                                      input logic [3:0] idx, input logic [31:0] v);
    w.typed = 1;
    w.ans   = '{st, idx, v};
    return w;
  endfunction

  initial begin
    logic [4:0] sizes [6] = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd3};
    rst              = 1'b1;
    cycles           = 0;
    errors           = 0;
    hold_go          = 0;
    burst_left       = 0;
    req.valid        = 1'b0;
    req.action       = ACT_GET;
    req.name_char    = 8'd0;
    req.char_present = 1'b0;
    req.last_char    = 1'b0;
    req.by_slot      = 1'b0;
    req.slot         = 4'd0;
    req.value        = 32'd0;
    cfg.valid        = 1'b0;
    cfg.pool_size    = 5'd16;
    size_reg         = 5'd16;
    reset_pool();
    clear_name();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(known(row(ACT_GET, "a", 1, 1, 0, 0, 0), ST_CLAIMED, 0, 0));
    directed.push_back(known(row(ACT_SET, "A", 1, 1, 0, 0, 32'hffff_ffff),
                             ST_FOUND, 0, 32'hffff_ffff));
    // empty name gives the bare prefix as key
    directed.push_back(known(row(ACT_GET, 8'hff, 0, 1, 0, 0, 0), ST_CLAIMED, 1, 0));
    directed.push_back(row(ACT_GET, "M", 1, 0, 0, 0, 0));
    directed.push_back(row(ACT_GET, "s", 1, 0, 0, 0, 0));
    directed.push_back(row(ACT_GET, "G", 1, 0, 0, 0, 0));
    directed.push_back(row(ACT_SET, "_", 1, 1, 0, 0, 32'h1234_5678));
    directed.push_back(known(row(ACT_SET, 0, 0, 1, 1, 15, 32'h8000_0000),
                             ST_FOUND, 15, 32'h8000_0000));
    directed.push_back(known(row(ACT_STEP, 0, 0, 1, 0, 0, 0), ST_FOUND, 0, 32'hffff_ffff));
    directed.push_back(row(ACT_STEP, 0, 0, 1, 1, 0, 0));
    directed.push_back(known(row(ACT_STEP, 0, 0, 1, 1, 1, 0), ST_NOENTRY, 0, 0));
    directed.push_back(known(row(ACT_STEP, 0, 0, 1, 1, 15, 0), ST_NOENTRY, 0, 0));
    directed.push_back(row(3'd5, "q", 1, 1, 0, 0, 0));
    directed.push_back(row(3'd7, 0, 0, 1, 1, 3, 0));
    directed.push_back(known(row(ACT_CLEAR, 0, 0, 1, 0, 0, 0), ST_DONE, 0, 0));
    directed.push_back(known(row(ACT_GET, 0, 0, 1, 1, 0, 0), ST_FOUND, 0, 0));
    // zero byte ends the name, the trailing byte is dropped
    directed.push_back(row(ACT_GET, "b", 1, 0, 0, 0, 0));
    directed.push_back(row(ACT_GET, 8'h00, 1, 0, 0, 0, 0));
    directed.push_back(row(ACT_GET, "c", 1, 1, 0, 0, 0));
    directed.push_back(row(ACT_GET, "B", 1, 1, 0, 0, 0));
    directed.push_back(known(row(ACT_RESET, 0, 0, 1, 0, 0, 0), ST_DONE, 0, 0));
    directed.push_back(known(row(ACT_STEP, 0, 0, 1, 0, 0, 0), ST_NOENTRY, 0, 0));

    foreach (directed[i]) begin
      send_word(directed[i]);
      pace();
    end

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_pool_size(sizes[ph]);
      send_word(word(ACT_RESET, 0, 1'b0, 1'b1));
      hold_go = 1;
      repeat (80) send_random_request();
    end

    wait_idle();
    if (errors == 0 && answer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: stalls in changing patterns, with one long hold-off once the random phases start
  initial begin
    int hold_cnt;
    int mode;
    int mode_left;
    hold_cnt  = 0;
    mode      = 0;
    mode_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && hold_cnt < HOLD_LEN) begin
        hold_cnt++;
        rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= 1'($urandom_range(0, 1));
          default: rsp.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // outputs are stable at the falling edge, between driving edges
  always @(negedge clk) begin
    answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (answer_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          errors++;
        end
        if (rsp.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, rsp.slot_index);
          errors++;
        end
        if (rsp.slot_value !== want.slot_value) begin
          $error("slot_value: expected %h, got %h", want.slot_value, rsp.slot_value);
          errors++;
        end
      end
    end
  end

endmodule
